FILE: rtl/core/assert_macros.svh
// Assertion macros used by the rasterizer controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/ter_pkg.sv
// Package: types and constants of the triangle edge rasterizer
package ter_pkg;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 512;
  localparam int AccW = 24;
  localparam int ProdW = 32;
  localparam int NumQ = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;
  localparam logic [1:0] CFG_LEFT = 2'd0;
  localparam logic [1:0] CFG_TOP = 2'd1;
  localparam logic [1:0] CFG_RIGHT = 2'd2;
  localparam logic [1:0] CFG_BOTTOM = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_AREA, S_SWAP, S_BOX, S_CHECK, S_EDGE, S_EDGE2, S_MAC, S_DIV, S_OUT
  } ter_state_t;

  typedef struct packed {
    logic       load_corner;
    logic       calc_area;
    logic       do_swap;
    logic       calc_box;
    logic       calc_edge;
    logic       calc_edge2;
    logic [1:0] mac_idx;
    logic       mac_clr;
    logic       mac_en;
    logic       div_start;
    logic       out_load;
    logic       out_done_only;
    logic       advance;
  } ter_cmd_t;

  typedef struct packed {
    logic area_neg;
    logic setup_empty;
    logic covered;
    logic div_busy;
    logic scan_last;
  } ter_stat_t;
endpackage

FILE: rtl/core/ter_if.sv
// Valid/ready channel interfaces: vertex input, pixel output, config write
interface ter_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [1:0]        vertex_slot;
  logic signed [10:0] vert_x;
  logic signed [10:0] vert_y;
  logic [4:0]        vert_red;
  logic [4:0]        vert_green;
  logic [4:0]        vert_blue;
  logic [7:0]        vert_u;
  logic [7:0]        vert_v;
  modport source (output valid, operation, vertex_slot, vert_x, vert_y, vert_red,
                  vert_green, vert_blue, vert_u, vert_v, input ready);
  modport sink (input valid, operation, vertex_slot, vert_x, vert_y, vert_red,
                vert_green, vert_blue, vert_u, vert_v, output ready);
endinterface

interface ter_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] pix_x;
  logic [8:0] pix_y;
  logic       covered;
  logic [4:0] pix_red;
  logic [4:0] pix_green;
  logic [4:0] pix_blue;
  logic [7:0] pix_u;
  logic [7:0] pix_v;
  logic       scan_done;
  modport source (output valid, pix_x, pix_y, covered, pix_red, pix_green, pix_blue,
                  pix_u, pix_v, scan_done, input ready);
  modport sink (input valid, pix_x, pix_y, covered, pix_red, pix_green, pix_blue,
                pix_u, pix_v, scan_done, output ready);
endinterface

interface ter_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ter_divider.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 24-bit divisor
module ter_divider import ter_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ProdW-1:0] dividend,
  input  logic [AccW-1:0]  divisor,
  output logic             busy,
  output logic [ProdW-1:0] quotient
);
  logic [AccW:0]   rem;
  logic [ProdW-1:0] quo;
  logic [AccW-1:0]  dvs;
  logic [5:0]       count;
  logic [AccW:0]    trial;

  assign trial = {rem[AccW-1:0], quo[ProdW-1]} - {1'b0, dvs};
  assign busy = (count != 6'd0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 6'd0;
    end else if (start) begin
      count <= 6'(ProdW);
    end else if (busy) begin
      count <= count - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[AccW]) begin
        rem <= trial;
        quo <= {quo[ProdW-2:0], 1'b1};
      end else begin
        rem <= {rem[AccW-1:0], quo[ProdW-1]};
        quo <= {quo[ProdW-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/core/ter_datapath.sv
// Datapath: corner store, area, clip box, edge functions, weighted sums, dividers
module ter_datapath import ter_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ter_cmd_t    cmd,
  output ter_stat_t   stat,
  input  logic [1:0]  slot,
  input  logic signed [10:0] in_x,
  input  logic signed [10:0] in_y,
  input  logic [4:0]  in_r,
  input  logic [4:0]  in_g,
  input  logic [4:0]  in_b,
  input  logic [7:0]  in_u,
  input  logic [7:0]  in_v,
  input  logic [10:0] area_left,
  input  logic [9:0]  area_top,
  input  logic [10:0] area_right,
  input  logic [9:0]  area_bottom,
  output logic [9:0]  o_x,
  output logic [8:0]  o_y,
  output logic        o_cov,
  output logic [4:0]  o_r,
  output logic [4:0]  o_g,
  output logic [4:0]  o_b,
  output logic [7:0]  o_u,
  output logic [7:0]  o_v,
  output logic        o_done
);
  logic signed [10:0] cx [3];
  logic signed [10:0] cy [3];
  logic [4:0] cr [3];
  logic [4:0] cg [3];
  logic [4:0] cb [3];
  logic [7:0] cu [3];
  logic [7:0] cv [3];
  logic signed [AccW-1:0] area;
  logic [AccW-1:0] darea;
  logic signed [12:0] bx0, by0, bx1, by1;
  logic signed [12:0] col, row;
  logic row_in;
  logic signed [AccW-1:0] w [3];
  logic signed [AccW-1:0] wa, wb;
  logic signed [11:0] ea, eb, ec, ed;
  logic [ProdW-1:0] acc [NumQ];
  logic [7:0] mv [NumQ];
  logic [1:0] mi;
  logic [ProdW-1:0] quo [NumQ];
  logic [NumQ-1:0] dbusy;
  logic cov;
  logic signed [12:0] nx;
  logic signed [12:0] minx, miny, maxx, maxy, x0n, y0n, x1n, y1n;

  function automatic logic signed [12:0] mn(input logic signed [12:0] a, b);
    return (a < b) ? a : b;
  endfunction
  function automatic logic signed [12:0] mx(input logic signed [12:0] a, b);
    return (a > b) ? a : b;
  endfunction

  assign minx = mn(mn(13'(cx[0]), 13'(cx[1])), 13'(cx[2]));
  assign maxx = mx(mx(13'(cx[0]), 13'(cx[1])), 13'(cx[2]));
  assign miny = mn(mn(13'(cy[0]), 13'(cy[1])), 13'(cy[2]));
  assign maxy = mx(mx(13'(cy[0]), 13'(cy[1])), 13'(cy[2]));
  assign x0n = mx(mx(13'(signed'({2'b0, area_left})), minx), 13'sd0);
  assign y0n = mx(mx(13'(signed'({3'b0, area_top})), miny), 13'sd0);
  assign x1n = mn(mn(13'(signed'({2'b0, area_right})), maxx), 13'(SCREEN_WIDTH));
  assign y1n = mn(mn(13'(signed'({3'b0, area_bottom})), maxy), 13'(SCREEN_HEIGHT));

  // edge(a,b,p) = (bx-ax)(py-ay) - (by-ay)(px-ax); w0:(1,2) w1:(2,0) w2:(0,1)
  always_comb begin
    ea = 12'(cx[2]) - 12'(cx[1]);
    eb = 12'(row) - 12'(cy[1]);
    ec = 12'(cy[2]) - 12'(cy[1]);
    ed = 12'(col) - 12'(cx[1]);
    if (cmd.calc_edge2) begin
      ea = 12'(cx[1]) - 12'(cx[0]);
      eb = 12'(row) - 12'(cy[0]);
      ec = 12'(cy[1]) - 12'(cy[0]);
      ed = 12'(col) - 12'(cx[0]);
    end else if (cmd.calc_area) begin
      ea = 12'(cx[1]) - 12'(cx[0]);
      eb = 12'(cy[2]) - 12'(cy[0]);
      ec = 12'(cy[1]) - 12'(cy[0]);
      ed = 12'(cx[2]) - 12'(cx[0]);
    end
    wa = AccW'(ea) * AccW'(eb) - AccW'(ec) * AccW'(ed);
    wb = AccW'(12'(cx[0]) - 12'(cx[2])) * AccW'(12'(row) - 12'(cy[2]))
       - AccW'(12'(cy[0]) - 12'(cy[2])) * AccW'(12'(col) - 12'(cx[2]));
  end

  assign cov = !w[0][AccW-1] && !w[1][AccW-1] && !w[2][AccW-1];
  assign nx = (cov || !row_in) ? col + 13'sd1 : bx1;

  assign stat.area_neg = area[AccW-1];
  assign stat.setup_empty = (darea == '0) || (bx0 >= bx1) || (by0 >= by1);
  assign stat.covered = cov;
  assign stat.div_busy = |dbusy;
  assign stat.scan_last = (nx >= bx1) && (row + 13'sd1 >= by1);

  always_comb begin
    mv[0] = 8'(cr[mi]);
    mv[1] = 8'(cg[mi]);
    mv[2] = 8'(cb[mi]);
    mv[3] = cu[mi];
    mv[4] = cv[mi];
  end
  assign mi = cmd.mac_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_corner) begin
      cx[slot] <= in_x;
      cy[slot] <= in_y;
      cr[slot] <= in_r;
      cg[slot] <= in_g;
      cb[slot] <= in_b;
      cu[slot] <= in_u;
      cv[slot] <= in_v;
    end
    if (cmd.do_swap) begin
      cx[1] <= cx[2]; cx[2] <= cx[1];
      cy[1] <= cy[2]; cy[2] <= cy[1];
      cr[1] <= cr[2]; cr[2] <= cr[1];
      cg[1] <= cg[2]; cg[2] <= cg[1];
      cb[1] <= cb[2]; cb[2] <= cb[1];
      cu[1] <= cu[2]; cu[2] <= cu[1];
      cv[1] <= cv[2]; cv[2] <= cv[1];
    end
    if (cmd.calc_area) area <= wa;
    if (cmd.calc_edge) begin
      w[0] <= wa;
      w[1] <= wb;
    end
    if (cmd.calc_edge2) w[2] <= wa;
    for (int k = 0; k < NumQ; k++) begin
      if (cmd.mac_clr) acc[k] <= '0;
      else if (cmd.mac_en) acc[k] <= acc[k] + ProdW'(mv[k]) * ProdW'(w[mi][AccW-2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      darea <= '0;
      bx0 <= '0; by0 <= '0; bx1 <= '0; by1 <= '0;
      col <= '0; row <= '0; row_in <= 1'b0;
    end else begin
      if (cmd.do_swap) darea <= AccW'(-area);
      else if (cmd.calc_box && !area[AccW-1]) darea <= area;
      if (cmd.calc_box) begin
        bx0 <= x0n; by0 <= y0n; bx1 <= x1n; by1 <= y1n;
        col <= x0n; row <= y0n; row_in <= 1'b0;
      end
      if (cmd.advance) begin
        if (nx >= bx1) begin
          col <= bx0;
          row <= row + 13'sd1;
          row_in <= 1'b0;
        end else begin
          col <= nx;
          row_in <= row_in | cov;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_x <= col[9:0];
      o_y <= row[8:0];
      o_cov <= cov;
      o_r <= cov ? quo[0][4:0] : 5'd0;
      o_g <= cov ? quo[1][4:0] : 5'd0;
      o_b <= cov ? quo[2][4:0] : 5'd0;
      o_u <= cov ? quo[3][7:0] : 8'd0;
      o_v <= cov ? quo[4][7:0] : 8'd0;
      o_done <= stat.scan_last;
    end else if (cmd.out_done_only) begin
      o_x <= '0; o_y <= '0; o_cov <= 1'b0;
      o_r <= '0; o_g <= '0; o_b <= '0; o_u <= '0; o_v <= '0;
      o_done <= 1'b1;
    end
  end

  for (genvar k = 0; k < NumQ; k++) begin : g_div
    ter_divider u_div (
      .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(acc[k]),
      .divisor(darea), .busy(dbusy[k]), .quotient(quo[k])
    );
  end
endmodule

FILE: rtl/core/ter_control.sv
// Controller: sequences setup and per-pixel work, drives the handshakes
module ter_control import ter_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [1:0] vertex_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output ter_cmd_t   cmd,
  input  ter_stat_t  stat
);
`include "assert_macros.svh"
  ter_state_t state, state_next;
  logic active, active_next;
  logic ovalid, ovalid_next;
  logic [1:0] midx, midx_next;
  logic acc;

  assign in_ready = (state == S_IDLE) && !ovalid;
  assign out_valid = ovalid;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= 1'b0;
      ovalid <= 1'b0;
      midx <= '0;
    end else begin
      state <= state_next;
      active <= active_next;
      ovalid <= ovalid_next;
      midx <= midx_next;
    end
  end

  always_comb begin
    state_next = state;
    active_next = active;
    ovalid_next = ovalid && !out_ready;
    midx_next = midx;
    cmd = '0;
    cmd.mac_idx = midx;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (operation == OP_LOAD) begin
            if (vertex_slot != 2'd3) begin
              cmd.load_corner = 1'b1;
              active_next = 1'b0;
              if (vertex_slot == 2'd2) state_next = S_AREA;
            end
          end else if (active) begin
            state_next = S_EDGE;
          end
        end
      end
      S_AREA: begin
        cmd.calc_area = 1'b1;
        state_next = S_SWAP;
      end
      S_SWAP: begin
        if (stat.area_neg) cmd.do_swap = 1'b1;
        state_next = S_BOX;
      end
      S_BOX: begin
        cmd.calc_box = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.setup_empty) begin
          cmd.out_done_only = 1'b1;
          ovalid_next = 1'b1;
        end else begin
          active_next = 1'b1;
        end
        state_next = S_IDLE;
      end
      S_EDGE: begin
        cmd.calc_edge = 1'b1;
        state_next = S_EDGE2;
      end
      S_EDGE2: begin
        cmd.calc_edge2 = 1'b1;
        cmd.mac_clr = 1'b1;
        midx_next = '0;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        midx_next = midx + 2'd1;
        if (midx == 2'd2) begin
          midx_next = '0;
          state_next = stat.covered ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.div_busy) begin
          cmd.out_load = 1'b1;
          cmd.advance = 1'b1;
          ovalid_next = 1'b1;
          if (stat.scan_last) active_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_ready_idle, in_ready, state == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_IMPL(a_no_scan_in_setup, state == S_EDGE, active, "scan without setup")
endmodule

FILE: rtl/core/triangle_edge_rasterizer_unit.sv
// Top level of the triangle edge rasterizer
// Channels: vin (vertex loads and step words), pout (pixel words), cfg
// (clip register writes, index 0..3 = left, top, right, bottom).
// A load word to slot 0, 1 or 2 stores that corner; loading slot 2 runs a setup
// (area, optional corner swap, clip box, check) and, for an empty or
// degenerate triangle, gives one word with scan_done set.
// A step word, while a scan is active, visits one pixel: edge functions,
// weighted sums over the three corners, then for a covered pixel five
// parallel restoring dividers, before the word is handed over.
// One item at a time: vin.ready is low while an item is in work or while
// the pout word has not been taken, so a stalled receiver stalls input.
// Reset (synchronous, rst high) idles the scan and restores the clip
// registers to the full 1024x512 screen; corner storage is not cleared.
// cfg writes are always taken; the user must write them only while the block is idle, which the block does not enforce.
module triangle_edge_rasterizer_unit import ter_pkg::*; (
  input logic clk,
  input logic rst,
  ter_in_if.sink    vin,
  ter_out_if.source pout,
  ter_cfg_if.sink   cfg
);
  ter_cmd_t  cmd;
  ter_stat_t stat;
  logic [10:0] area_left, area_right;
  logic [9:0]  area_top, area_bottom;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_left <= '0;
      area_top <= '0;
      area_right <= 11'(SCREEN_WIDTH);
      area_bottom <= 10'(SCREEN_HEIGHT);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LEFT:   area_left <= cfg.data;
        CFG_TOP:    area_top <= cfg.data[9:0];
        CFG_RIGHT:  area_right <= cfg.data;
        CFG_BOTTOM: area_bottom <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  ter_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(vin.valid), .in_ready(vin.ready),
    .operation(vin.operation), .vertex_slot(vin.vertex_slot),
    .out_valid(pout.valid), .out_ready(pout.ready), .cmd(cmd), .stat(stat)
  );

  ter_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .slot(vin.vertex_slot),
    .in_x(vin.vert_x), .in_y(vin.vert_y), .in_r(vin.vert_red),
    .in_g(vin.vert_green), .in_b(vin.vert_blue), .in_u(vin.vert_u), .in_v(vin.vert_v),
    .area_left(area_left), .area_top(area_top), .area_right(area_right),
    .area_bottom(area_bottom),
    .o_x(pout.pix_x), .o_y(pout.pix_y), .o_cov(pout.covered), .o_r(pout.pix_red),
    .o_g(pout.pix_green), .o_b(pout.pix_blue), .o_u(pout.pix_u), .o_v(pout.pix_v),
    .o_done(pout.scan_done)
  );
endmodule

FILE: tb/ter_checker.sv
// Scoreboard for the rasterizer: predicts pixel words from vin and cfg and compares them
module ter_checker import ter_pkg::*; (
  input  logic clk,
  input  logic rst,
  ter_in_if    vin,
  ter_out_if   pout,
  ter_cfg_if   cfg,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint x, y, r, g, b, u, v;
  } corner_t;

  typedef struct packed {
    logic [9:0] x;
    logic [8:0] y;
    logic       cov;
    logic [4:0] r, g, b;
    logic [7:0] u, v;
    logic       done;
  } pix_word_t;

  pix_word_t exp_pixels[$];
  corner_t   corners[3];
  longint    clip_left, clip_top, clip_right, clip_bottom;
  longint    area2, bx0, bx1, by0, by1, col, row;
  bit        in_row, scanning;

  assign pending = exp_pixels.size();

  function automatic longint edge_fn(corner_t a, corner_t b, longint px, longint py);
    return (b.x - a.x) * (py - a.y) - (b.y - a.y) * (px - a.x);
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  task automatic predict_word();
    pix_word_t w;
    corner_t   t;
    longint    a, e0, e1, e2, nxt;
    int        s;
    w = '0;
    if (vin.operation == OP_LOAD) begin
      s = vin.vertex_slot;
      if (s == 3) return;
      scanning = 0;
      corners[s].x = longint'(vin.vert_x);
      corners[s].y = longint'(vin.vert_y);
      corners[s].r = vin.vert_red;
      corners[s].g = vin.vert_green;
      corners[s].b = vin.vert_blue;
      corners[s].u = vin.vert_u;
      corners[s].v = vin.vert_v;
      if (s != 2) return;
      a = edge_fn(corners[0], corners[1], corners[2].x, corners[2].y);
      if (a < 0) begin
        t = corners[1];
        corners[1] = corners[2];
        corners[2] = t;
        a = -a;
      end
      area2 = a;
      bx0 = lmax(clip_left, lmax(lmin(corners[0].x, lmin(corners[1].x, corners[2].x)), 0));
      by0 = lmax(clip_top, lmax(lmin(corners[0].y, lmin(corners[1].y, corners[2].y)), 0));
      bx1 = lmin(clip_right, lmin(lmax(corners[0].x, lmax(corners[1].x, corners[2].x)),
                                  SCREEN_WIDTH));
      by1 = lmin(clip_bottom, lmin(lmax(corners[0].y, lmax(corners[1].y, corners[2].y)),
                                   SCREEN_HEIGHT));
      if (a == 0 || bx0 >= bx1 || by0 >= by1) begin
        w.done = 1;
        exp_pixels.push_back(w);
        return;
      end
      col = bx0;
      row = by0;
      in_row = 0;
      scanning = 1;
      return;
    end
    if (!scanning) return;
    e0 = edge_fn(corners[1], corners[2], col, row);
    e1 = edge_fn(corners[2], corners[0], col, row);
    e2 = edge_fn(corners[0], corners[1], col, row);
    w.x = col[9:0];
    w.y = row[8:0];
    w.cov = (e0 >= 0 && e1 >= 0 && e2 >= 0);
    if (w.cov && area2 > 0) begin
      w.r = (corners[0].r * e0 + corners[1].r * e1 + corners[2].r * e2) / area2;
      w.g = (corners[0].g * e0 + corners[1].g * e1 + corners[2].g * e2) / area2;
      w.b = (corners[0].b * e0 + corners[1].b * e1 + corners[2].b * e2) / area2;
      w.u = (corners[0].u * e0 + corners[1].u * e1 + corners[2].u * e2) / area2;
      w.v = (corners[0].v * e0 + corners[1].v * e1 + corners[2].v * e2) / area2;
    end
    if (w.cov) begin
      in_row = 1;
      nxt = col + 1;
    end else if (in_row) begin
      nxt = bx1;
    end else begin
      nxt = col + 1;
    end
    if (nxt >= bx1) begin
      col = bx0;
      row = row + 1;
      in_row = 0;
      if (row >= by1) begin
        scanning = 0;
        w.done = 1;
      end
    end else begin
      col = nxt;
    end
    exp_pixels.push_back(w);
  endtask

  task automatic compare_word();
    pix_word_t got, want;
    got = {pout.pix_x, pout.pix_y, pout.covered, pout.pix_red, pout.pix_green,
           pout.pix_blue, pout.pix_u, pout.pix_v, pout.scan_done};
    if (exp_pixels.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected pixel word %p", got);
      return;
    end
    want = exp_pixels.pop_front();
    if (got !== want) begin
      fails++;
      if (fails <= 10) $display("pixel mismatch: expected %p, got %p", want, got);
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (rst) begin
      exp_pixels.delete();
      clip_left <= 0;
      clip_top <= 0;
      clip_right <= 1024;
      clip_bottom <= 512;
      area2 = 0;
      bx0 = 0; bx1 = 0; by0 = 0; by1 = 0;
      col = 0; row = 0;
      in_row = 0;
      scanning = 0;
    end else begin
      if (pout.valid && pout.ready) compare_word();
      if (vin.valid && vin.ready) predict_word();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_LEFT:   clip_left <= cfg.data;
          CFG_TOP:    clip_top <= cfg.data[9:0];
          CFG_RIGHT:  clip_right <= cfg.data;
          CFG_BOTTOM: clip_bottom <= cfg.data[9:0];
          default: ;
        endcase
      end
    end
  end

  final if (exp_pixels.size() != 0) ;
endmodule

FILE: tb/tb_top.sv
// Testbench top: drives vertex, step and clip-register words into the rasterizer and gives the verdict
module tb_top import ter_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 3000000;

  logic clk, rst;
  int   fails, pending, sent, src_idle, snk_stall;
  longint cycles;

  ter_in_if  vin_ch();
  ter_out_if pout_ch();
  ter_cfg_if cfg_ch();

  triangle_edge_rasterizer_unit dut (.clk(clk), .rst(rst), .vin(vin_ch), .pout(pout_ch),
                                     .cfg(cfg_ch));

  ter_checker u_chk (.clk(clk), .rst(rst), .vin(vin_ch), .pout(pout_ch), .cfg(cfg_ch),
                     .fails(fails), .pending(pending));

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    pout_ch.ready <= ($urandom_range(99) >= snk_stall);
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [1:0] slot, logic [10:0] x, logic [10:0] y,
                           logic [4:0] r, logic [4:0] g, logic [4:0] b,
                           logic [7:0] u, logic [7:0] v);
    if ($urandom_range(99) < src_idle) begin
      vin_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    vin_ch.operation <= op;
    vin_ch.vertex_slot <= slot;
    vin_ch.vert_x <= x;
    vin_ch.vert_y <= y;
    vin_ch.vert_red <= r;
    vin_ch.vert_green <= g;
    vin_ch.vert_blue <= b;
    vin_ch.vert_u <= u;
    vin_ch.vert_v <= v;
    vin_ch.valid <= 1;
    @(posedge clk);
    while (!vin_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic load(logic [1:0] slot, logic [10:0] x, logic [10:0] y);
    send_word(OP_LOAD, slot, x, y, 5'($urandom), 5'($urandom), 5'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  task automatic step(int n);
    repeat (n) send_word(OP_STEP, 2'($urandom), 11'($urandom), 11'($urandom),
                         5'($urandom), 5'($urandom), 5'($urandom),
                         8'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    vin_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [10:0] near(int center, int spread);
    if ($urandom_range(9) == 0) return 11'($urandom);
    return 11'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic random_triangle();
    int cx, cy, sp;
    cx = $urandom_range(0, 1100) - 40;
    cy = $urandom_range(0, 580) - 40;
    sp = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 10);
    if ($urandom_range(4) == 0) begin
      load(2'($urandom_range(0, 2)), near(cx, sp), near(cy, sp));
    end else begin
      load(0, near(cx, sp), near(cy, sp));
      load(1, near(cx, sp), near(cy, sp));
      load(2, near(cx, sp), near(cy, sp));
    end
    step(($urandom_range(3) == 0) ? 150 : $urandom_range(1, 40));
  endtask

  function automatic logic [10:0] pick_reg(int full);
    case ($urandom_range(5))
      0: return 11'd0;
      1: return 11'(full);
      2: return 11'($urandom);
      default: return 11'($urandom_range(0, full));
    endcase
  endfunction

  initial begin
    int goal;
    rst = 1;
    cycles = 0;
    sent = 0;
    src_idle = 0;
    snk_stall = 0;
    vin_ch.valid = 0;
    vin_ch.operation = OP_LOAD;
    vin_ch.vertex_slot = 0;
    vin_ch.vert_x = 0;
    vin_ch.vert_y = 0;
    vin_ch.vert_red = 0;
    vin_ch.vert_green = 0;
    vin_ch.vert_blue = 0;
    vin_ch.vert_u = 0;
    vin_ch.vert_v = 0;
    pout_ch.ready = 1;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_LEFT;
    cfg_ch.data = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // full-range corners and extreme attributes
    send_word(OP_LOAD, 0, -11'sd1024, -11'sd1024, 0, 0, 0, 0, 0);
    send_word(OP_LOAD, 1, 11'sd1023, -11'sd1024, 31, 31, 31, 255, 255);
    send_word(OP_LOAD, 2, 0, 11'sd1023, 31, 0, 31, 0, 255);
    step(3);
    // clockwise triangle gets swapped
    send_word(OP_LOAD, 0, 10, 10, 31, 31, 31, 255, 255);
    send_word(OP_LOAD, 1, 10, 14, 0, 31, 0, 255, 0);
    send_word(OP_LOAD, 2, 14, 10, 31, 0, 0, 0, 255);
    step(8);
    // reload of slot 2 alone, then ignored slot and a step
    send_word(OP_LOAD, 2, 10, 20, 5, 5, 5, 5, 5);
    send_word(OP_LOAD, 3, 1, 1, 1, 1, 1, 1, 1);
    step(1);
    // load in the middle of a scan
    load(0, 100, 100);
    load(1, 106, 100);
    load(2, 100, 106);
    step(2);
    load(0, 101, 99);
    step(1);
    load(2, 99, 107);
    step(3);
    // off-screen triangle
    load(0, -50, -50);
    load(1, -10, -50);
    load(2, -50, -10);
    settle();
    write_reg(CFG_LEFT, 1024);
    write_reg(CFG_TOP, 512);
    write_reg(CFG_RIGHT, 0);
    write_reg(CFG_BOTTOM, 0);
    load(2, 20, 20);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 33) : 0;
      snk_stall = (ph == 2) ? 74 : ((ph == 3) ? 33 : 0);
      if (ph == 0) begin
        write_reg(CFG_LEFT, 0);
        write_reg(CFG_TOP, 0);
        write_reg(CFG_RIGHT, 1024);
        write_reg(CFG_BOTTOM, 512);
      end else begin
        write_reg(CFG_LEFT, pick_reg(1024));
        write_reg(CFG_TOP, pick_reg(512));
        write_reg(CFG_RIGHT, ($urandom_range(2) == 0) ? pick_reg(1024) : 11'd1024);
        write_reg(CFG_BOTTOM, ($urandom_range(2) == 0) ? pick_reg(512) : 11'd512);
      end
      goal = sent + 460;
      while (sent < goal) begin
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) load(2'd3, 11'($urandom), 11'($urandom));
          else step(1);
        end else begin
          random_triangle();
        end
      end
      load(2'd0, 11'($urandom), 11'($urandom));
      settle();
    end

    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
